/* hw/rtl/slcan_text_frame_parser_defines.svh */
// Assertion macros shared by the parser RTL.
// Each macro expects clk and rst_n to be in scope.
`ifndef SLCAN_TEXT_FRAME_PARSER_DEFINES_SVH
`define SLCAN_TEXT_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define SLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slcan parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define SLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcan parser: next-cycle check failed");

`else

`define SLC_ASSERT_SAME(lbl, ante, cons)
`define SLC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/slcan_tfp_pkg.sv */
package slcan_tfp_pkg;

  // Start-of-frame character 'T'
  localparam logic [7:0] START_CHAR = 8'h54;

  // Digit counter covers eight identifier digits and up to sixteen data digits
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] ID_LAST = 4'd7;

  // Token queue between classifier and parser
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // One classified character
  typedef struct packed {
    logic       is_start;
    logic       is_hex;
    logic [3:0] hex_val;
  } token_t;

endpackage

/* hw/rtl/slcan_tfp_front.sv */
module slcan_tfp_front
  import slcan_tfp_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output token_t     q_tok
);

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Classify the character: start marker and hex digit value
  always_comb begin
    q_tok          = '0;
    q_tok.is_start = (in_rx_byte == START_CHAR);
    if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      q_tok.is_hex  = 1'b1;
      q_tok.hex_val = 4'(in_rx_byte - 8'h30);
    end else if (in_rx_byte >= 8'h41 && in_rx_byte <= 8'h46) begin
      q_tok.is_hex  = 1'b1;
      q_tok.hex_val = 4'(in_rx_byte - 8'h37);
    end else if (in_rx_byte >= 8'h61 && in_rx_byte <= 8'h66) begin
      q_tok.is_hex  = 1'b1;
      q_tok.hex_val = 4'(in_rx_byte - 8'h57);
    end
  end

endmodule

/* hw/rtl/slcan_tfp_queue.sv */
module slcan_tfp_queue
  import slcan_tfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output token_t pop_tok
);

  token_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_tok   = ent_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && pop_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_tok;
  end

endmodule

/* hw/rtl/slcan_tfp_back.sv */
module slcan_tfp_back
  import slcan_tfp_pkg::*;
#(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tok_valid,
  input  token_t      tok,
  output logic        tok_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_can_id,
  output logic [3:0]  out_byte_cnt,
  output logic [63:0] out_data_bytes
);

  localparam int unsigned NIBS   = 2 * MAX_DATA_BYTES;
  localparam int unsigned NIB_W  = $clog2(NIBS);
  localparam int unsigned DATA_W = 8 * MAX_DATA_BYTES;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_ID   = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]        len_r, len_nxt;
  logic [31:0]       id_r, id_nxt;
  logic [3:0]        nib_r [NIBS];
  logic [3:0]        nib_nxt [NIBS];

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [31:0]       out_can_id_r, out_can_id_nxt;
  logic [3:0]        out_len_r, out_len_nxt;
  logic [63:0]       out_data_r, out_data_nxt;

  logic              emit_good, emit_err, emit, slot_free, fire;
  logic              bad_len, last_data;
  logic [NIB_W-1:0]  nib_idx;
  logic [DATA_W-1:0] data_w;

  // Result classification for the token at the queue head
  assign bad_len   = (tok.hex_val == 4'd0) || (tok.hex_val > 4'(MAX_DATA_BYTES));
  assign last_data = ({1'b0, cnt_r} == (5'({len_r, 1'b0}) - 5'd1));
  assign emit_good = (phase_r == PH_DATA) && tok.is_hex && last_data;
  assign emit_err  = (phase_r != PH_HUNT) &&
                     (!tok.is_hex || ((phase_r == PH_LEN) && bad_len));
  assign emit      = emit_good || emit_err;

  // Tokens without a result never wait on the output register
  assign slot_free = !out_valid_r || out_ready;
  assign tok_pop   = tok_valid && (!emit || slot_free);
  assign fire      = tok_pop;

  // High nibble of each byte arrives first
  assign nib_idx = cnt_r[NIB_W-1:0] ^ NIB_W'(1);

  // Parser state machine
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    id_nxt    = id_r;
    for (int i = 0; i < NIBS; i++) nib_nxt[i] = nib_r[i];
    if (fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (tok.is_start) begin
            phase_nxt = PH_ID;
            cnt_nxt   = '0;
            for (int i = 0; i < NIBS; i++) nib_nxt[i] = 4'd0;
          end
        end
        PH_ID: begin
          if (!tok.is_hex) begin
            phase_nxt = PH_HUNT;
          end else begin
            id_nxt  = {id_r[27:0], tok.hex_val};
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == ID_LAST) begin
              phase_nxt = PH_LEN;
              cnt_nxt   = '0;
            end
          end
        end
        PH_LEN: begin
          if (!tok.is_hex || bad_len) begin
            phase_nxt = PH_HUNT;
          end else begin
            len_nxt   = tok.hex_val;
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (!tok.is_hex) begin
            phase_nxt = PH_HUNT;
          end else begin
            nib_nxt[nib_idx] = tok.hex_val;
            cnt_nxt          = cnt_r + 1'b1;
            if (last_data) phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Payload word including the digit taken this cycle
  always_comb begin
    for (int i = 0; i < NIBS; i++) data_w[i*4 +: 4] = nib_nxt[i];
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_can_id_nxt = out_can_id_r;
    out_len_nxt    = out_len_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
      if (emit_err) begin
        out_kind_nxt   = KIND_ERROR;
        out_can_id_nxt = '0;
        out_len_nxt    = '0;
        out_data_nxt   = '0;
      end else begin
        out_kind_nxt   = KIND_FRAME;
        out_can_id_nxt = id_r;
        out_len_nxt    = len_r;
        out_data_nxt   = 64'(data_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      cnt_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    out_kind_r   <= out_kind_nxt;
    out_can_id_r <= out_can_id_nxt;
    out_len_r    <= out_len_nxt;
    out_data_r   <= out_data_nxt;
    for (int i = 0; i < NIBS; i++) nib_r[i] <= nib_nxt[i];
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_can_id     = out_can_id_r;
  assign out_byte_cnt   = out_len_r;
  assign out_data_bytes = out_data_r;

endmodule

/* hw/rtl/slcan_text_frame_parser.sv */
// Channel   Handshake             Request contents
// in        in_valid / in_ready   in_rx_byte: one received character
// out       out_valid / out_ready kind, can_id, byte_cnt, data_bytes
//
// One character per cycle sustained while the queue has room; a result is
// registered and offered once the character that completes or breaks a frame is parsed.
// The classifier feeds a two-entry token queue; the parser drains one token
// per cycle, unless the output stalls, into a single output register.
// A stalled output holds only tokens that produce a result; others still drain.
// Reset is synchronous, active low, and returns the parser to hunting for 'T'.
`include "slcan_text_frame_parser_defines.svh"

module slcan_text_frame_parser
  import slcan_tfp_pkg::*;
#(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_can_id,
  output logic [3:0]  out_byte_cnt,
  output logic [63:0] out_data_bytes
);

  logic   q_full, q_push, q_pop, q_valid;
  token_t q_in_tok, q_out_tok;

  // Character classifier
  slcan_tfp_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_tok      (q_in_tok)
  );

  // Token queue
  slcan_tfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_in_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_tok   (q_out_tok)
  );

  // Frame parser and output register
  slcan_tfp_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (q_valid),
    .tok            (q_out_tok),
    .tok_pop        (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_can_id     (out_can_id),
    .out_byte_cnt   (out_byte_cnt),
    .out_data_bytes (out_data_bytes)
  );

  // Error results carry no frame contents
  `SLC_ASSERT_SAME(a_err_zero, out_valid && (out_kind == KIND_ERROR), (out_can_id == 32'd0) && (out_byte_cnt == 4'd0) && (out_data_bytes == 64'd0))
  // Decoded frames have a legal length
  `SLC_ASSERT_SAME(a_len_ok, out_valid && (out_kind == KIND_FRAME), (out_byte_cnt != 4'd0) && (out_byte_cnt <= 4'(MAX_DATA_BYTES)))
  // Input back-pressure only follows a stalled result
  `SLC_ASSERT_SAME(a_stall_cause, $fell(in_ready), $past(out_valid && !out_ready))

endmodule
